// ----- design/qb64_pkg.sv -----
// Shared types, constants and the alphabet lookup of the quoted base64 encoder.
`default_nettype none
package qb64_pkg;

    localparam int CHAR_W    = 8;
    localparam int MAX_CHARS = 6;
    localparam int CNT_W     = 3;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [CHAR_W-1:0] QUOTE_CHAR = 8'h22;
    localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h3D;

    // bytes taken so far in the current three-byte group
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    // one input transaction's worth of characters, lowest slot first
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]                 count;
        logic                             ends;   // last slot is the closing quote
    } cmd_t;

    // queue status seen by the back end
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 6'd26)
            r = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            r = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            r = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            r = 8'h2B;
        else
            r = 8'h2F;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/qb64_front.sv -----
// Front end: accepts bytes, tracks the group state and builds character commands.
`default_nettype none
module qb64_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [7:0]      data_byte,
    input  wire logic            last_byte,
    input  wire logic            empty_string,
    input  wire logic            q_full,
    output logic                 in_ready,
    output logic                 push,
    output qb64_pkg::cmd_t       cmd
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       open_reg,  open_next;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        logic [qb64_pkg::CNT_W-1:0] n;
        logic                       fin;
        cmd        = '0;
        n          = '0;
        fin        = 1'b0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        open_next  = open_reg;
        if (empty_string)
        begin
            if (!open_reg)
            begin
                cmd.chars[n] = qb64_pkg::QUOTE_CHAR;
                n            = n + 3'd1;
                phase_next   = qb64_pkg::PH_0;
                carry_next   = '0;
            end
            fin = 1'b1;
        end
        else
        begin
            if (!open_reg)
            begin
                cmd.chars[n] = qb64_pkg::QUOTE_CHAR;
                n            = n + 3'd1;
                open_next    = 1'b1;
                phase_next   = qb64_pkg::PH_0;
                carry_next   = '0;
            end
            case (phase_next)
                qb64_pkg::PH_1:
                begin
                    cmd.chars[n] = qb64_pkg::b64_char({carry_next[1:0], data_byte[7:4]});
                    n            = n + 3'd1;
                    carry_next   = data_byte[3:0];
                    phase_next   = qb64_pkg::PH_2;
                end
                qb64_pkg::PH_2:
                begin
                    cmd.chars[n] = qb64_pkg::b64_char({carry_next, data_byte[7:6]});
                    n            = n + 3'd1;
                    cmd.chars[n] = qb64_pkg::b64_char(data_byte[5:0]);
                    n            = n + 3'd1;
                    carry_next   = '0;
                    phase_next   = qb64_pkg::PH_0;
                end
                default:
                begin
                    // phase three never arises; handled as phase zero
                    cmd.chars[n] = qb64_pkg::b64_char(data_byte[7:2]);
                    n            = n + 3'd1;
                    carry_next   = {2'b00, data_byte[1:0]};
                    phase_next   = qb64_pkg::PH_1;
                end
            endcase
            fin = last_byte;
        end
        if (fin)
        begin
            case (phase_next)
                qb64_pkg::PH_1:
                begin
                    cmd.chars[n] = qb64_pkg::b64_char({carry_next[1:0], 4'b0000});
                    n            = n + 3'd1;
                    cmd.chars[n] = qb64_pkg::PAD_CHAR;
                    n            = n + 3'd1;
                    cmd.chars[n] = qb64_pkg::PAD_CHAR;
                    n            = n + 3'd1;
                end
                qb64_pkg::PH_2:
                begin
                    cmd.chars[n] = qb64_pkg::b64_char({carry_next, 2'b00});
                    n            = n + 3'd1;
                    cmd.chars[n] = qb64_pkg::PAD_CHAR;
                    n            = n + 3'd1;
                end
                default:
                begin
                end
            endcase
            cmd.chars[n] = qb64_pkg::QUOTE_CHAR;
            n            = n + 3'd1;
            cmd.ends     = 1'b1;
            phase_next   = qb64_pkg::PH_0;
            carry_next   = '0;
            open_next    = 1'b0;
        end
        cmd.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= qb64_pkg::PH_0;
            carry_reg <= '0;
            open_reg  <= 1'b0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            open_reg  <= open_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/qb64_queue.sv -----
// Short command queue between front end and back end.
`default_nettype none
module qb64_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire qb64_pkg::cmd_t    wr_cmd,
    input  wire logic              pop,
    output qb64_pkg::cmd_t         rd_cmd,
    output qb64_pkg::q_stat_t      stat
);

    qb64_pkg::cmd_t mem [qb64_pkg::QDEPTH];

    logic [qb64_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [qb64_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [qb64_pkg::QCNT_W-1:0] cnt_reg,    cnt_next;

    assign stat.full  = (cnt_reg == qb64_pkg::QCNT_W'(qb64_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_cmd     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + qb64_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + qb64_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + qb64_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - qb64_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/qb64_back.sv -----
// Back end: walks each command into the output register one character per cycle while out_ready allows.
`default_nettype none
module qb64_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qb64_pkg::cmd_t    q_cmd,
    input  wire qb64_pkg::q_stat_t q_stat,
    output logic                   pop,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [7:0]             out_char,
    output logic                   last_char
);

    qb64_pkg::cmd_t              cmd_reg, cmd_next;
    logic                        cmd_valid_reg, cmd_valid_next;
    logic [qb64_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_char_reg, out_char_next;
    logic                        out_last_reg, out_last_next;

    logic load_out, emit, cmd_done;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = out_last_reg;

    always_comb
    begin
        load_out = !out_valid_reg || out_ready;
        emit     = load_out && cmd_valid_reg;
        cmd_done = emit && (idx_reg == cmd_reg.count - 3'd1);
        pop      = !q_stat.empty && (!cmd_valid_reg || cmd_done);
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cmd_next       = q_cmd;
            cmd_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (cmd_done)
            cmd_valid_next = 1'b0;
        else if (emit)
            idx_next = idx_reg + 3'd1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = emit;
            out_char_next  = cmd_reg.chars[idx_reg];
            out_last_next  = cmd_done && cmd_reg.ends;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/quoted_base64_encoder.sv -----
// Top level of the quoted base64 encoder: front end, command queue, back end.
// A byte's command passes through the queue, then cmd_reg, then the output register to m_axis.
// Throughput: one input transaction per cycle while the 4-entry queue has room;
//   the output emits one character per cycle while m_axis_tready is high, so the
//   sustained rate is set by the characters per byte (4/3 plus quotes and pads, up to 6 for one byte).
// Reset: rst_n asynchronous active low; clears group state, queue and output valid.
`default_nettype none
module quoted_base64_encoder
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // last_byte
    input  wire logic       s_axis_tuser,   // [0] empty_string
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic            m_axis_tlast    // last_char
);

    qb64_pkg::cmd_t    push_cmd;
    qb64_pkg::cmd_t    head_cmd;
    qb64_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    // Front end: classifies each byte and emits a bundle of up to six characters.
    qb64_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .data_byte    (s_axis_tdata),
        .last_byte    (s_axis_tlast),
        .empty_string (s_axis_tuser),
        .q_full       (q_stat.full),
        .in_ready     (s_axis_tready),
        .push         (push),
        .cmd          (push_cmd)
    );

    // Queue decouples byte intake from character output.
    qb64_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .rd_cmd (head_cmd),
        .stat   (q_stat)
    );

    // Back end: serializes each bundle into the registered output stream.
    qb64_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_char  (m_axis_tdata),
        .last_char (m_axis_tlast)
    );

    // every pushed bundle carries at least one character
    a_cmd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_cmd.count != '0))
        else $error("empty command pushed");

    // back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue underflow");

    // the transaction that ends a string is always the closing quote
    a_last_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == qb64_pkg::QUOTE_CHAR))
        else $error("last character is not a quote");

endmodule
`default_nettype wire
